// ===== design/dac_sine_table_point_unit_defines.svh =====
// assertion macros shared by the checker
`ifndef DAC_SINE_TABLE_POINT_UNIT_DEFINES_SVH
`define DAC_SINE_TABLE_POINT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DSTP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dstp check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DSTP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dstp check failed");

`endif

// ===== design/dstp_pkg.sv =====
// types, constants and the arctangent table of the sine table point unit
package dstp_pkg;

    localparam int IDX_W     = 16;
    localparam int FRAC_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMPLITUDE = 2'd0,
        REG_VALLEY    = 2'd1,
        REG_POINTS    = 2'd2
    } cfg_reg_t;

    // cordic datapath, q2.30 with headroom
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 34;
    typedef logic signed [CORDIC_W-1:0] cordic_t;
    localparam cordic_t    CORDIC_X0   = 34'sd652032874;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic cordic_t atan_q30(input int step);
        cordic_t a;
        case (step)
            0:       a = 34'sd843314857;
            1:       a = 34'sd497837829;
            2:       a = 34'sd263043836;
            3:       a = 34'sd133525158;
            4:       a = 34'sd67021686;
            5:       a = 34'sd33543515;
            6:       a = 34'sd16775850;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194282;
            9:       a = 34'sd2097149;
            10:      a = 34'sd1048575;
            11:      a = 34'sd524287;
            12:      a = 34'sd262143;
            13:      a = 34'sd131071;
            14:      a = 34'sd65535;
            15:      a = 34'sd32767;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== design/dstp_ifs.sv =====
// request channel interfaces: point index in, dac code out
interface dstp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] point_index;
    modport source (output valid, output point_index, input ready);
    modport sink (input valid, input point_index, output ready);
endinterface

interface dstp_out_if #(parameter int CODE_W = 12);
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] dac_code;
    logic [15:0]       index_echo;
    logic              index_invalid;
    modport source (output valid, output dac_code, output index_echo,
                     output index_invalid, input ready);
    modport sink (input valid, input dac_code, input index_echo,
                   input index_invalid, output ready);
endinterface

// ===== design/dstp_front.sv =====
// front end: range check and pipelined phase division, one quotient bit a stage
module dstp_front
    import dstp_pkg::*;
#(
    parameter int PHASE_BITS = 16,
    localparam int NS = PHASE_BITS + 1,
    localparam int QW = IDX_W + 1 + PHASE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    dstp_in_if.sink            in_ch,
    input  logic [IDX_W-1:0]   points,
    input  q_status_t          q_stat,
    output logic               push,
    output logic [QW-1:0]      push_data
);

    logic             vld_reg [0:NS];
    logic [IDX_W-1:0] idx_reg [0:NS];
    logic             inv_reg [0:NS];
    logic [IDX_W-1:0] rem_reg [0:NS];
    logic [NS-1:0]    quo_reg [0:NS];
    logic             fe;
    logic             in_inv;
    logic [NS:0]      quo_inc;

    // whole front advances together unless the queue is full and the last stage is occupied
    assign fe          = !vld_reg[NS] || !q_stat.full;
    assign in_ch.ready = fe;
    assign in_inv      = (in_ch.point_index >= points);

    // stage zero: capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (fe)
        begin
            vld_reg[0] <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            idx_reg[0] <= in_ch.point_index;
            inv_reg[0] <= in_inv;
            rem_reg[0] <= in_inv ? '0 : in_ch.point_index;
            quo_reg[0] <= '0;
        end
    end

    // restoring division stages
    for (genvar k = 1; k <= NS; k++)
    begin : g_div
        logic [IDX_W:0] sh;
        logic           ge;

        assign sh = {rem_reg[k-1], 1'b0};
        assign ge = (sh >= {1'b0, points});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (fe)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (fe)
            begin
                idx_reg[k] <= idx_reg[k-1];
                inv_reg[k] <= inv_reg[k-1];
                rem_reg[k] <= ge ? IDX_W'(sh - {1'b0, points}) : sh[IDX_W-1:0];
                quo_reg[k] <= {quo_reg[k-1][NS-2:0], ge};
            end
        end
    end

    // round half up and wrap the phase
    assign quo_inc   = {1'b0, quo_reg[NS]} + (NS+1)'(1);
    assign push      = vld_reg[NS] && !q_stat.full;
    assign push_data = {idx_reg[NS], inv_reg[NS], quo_inc[PHASE_BITS:1]};

endmodule

// ===== design/dstp_queue.sv =====
// short queue between front and back end
module dstp_queue
    import dstp_pkg::*;
#(
    parameter int W = 33,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output q_status_t    q_stat
);

    logic [W-1:0] ent_reg [0:DEPTH-1];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          do_pop;

    assign do_pop       = pop && (cnt_reg != '0);
    assign q_stat.full  = (cnt_reg == (AW+1)'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign pop_data     = ent_reg[rd_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + AW'(1);
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + (AW+1)'(1);
            end
            else if (!push && do_pop)
            begin
                cnt_reg <= cnt_reg - (AW+1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ===== design/dstp_back.sv =====
// back end: cordic sine pipeline, scaling, clamp and round
module dstp_back
    import dstp_pkg::*;
#(
    parameter int PHASE_BITS = 16,
    parameter int DAC_MAX_CODE = 4095,
    parameter int CODE_W = 12,
    localparam int QW = IDX_W + 1 + PHASE_BITS,
    localparam int PW = CODE_W + 17,
    localparam int TW = CODE_W + 35,
    localparam int RW = PHASE_BITS - 2,
    localparam int MW = RW + 31
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [FRAC_W-1:0] amplitude,
    input  logic [FRAC_W-1:0] valley,
    input  logic [QW-1:0]     pop_data,
    input  q_status_t         q_stat,
    output logic              pop,
    dstp_out_if.source        out_ch
);

    localparam logic [PW-1:0] FULL = PW'(64'(DAC_MAX_CODE) << 16);
    localparam logic signed [TW-1:0] TOP  = TW'(64'(DAC_MAX_CODE) << 32);
    localparam logic signed [TW-1:0] HALF = TW'(64'd1 << 31);

    logic [FRAC_W-1:0] a_min, v_min;
    logic [PW-1:0]     ppraw_reg, lo_reg, pp_reg, lo2_reg;
    logic              be;

    logic             cv_reg  [0:CORDIC_STEPS];
    cordic_t          x_reg   [0:CORDIC_STEPS];
    cordic_t          y_reg   [0:CORDIC_STEPS];
    cordic_t          z_reg   [0:CORDIC_STEPS];
    logic [1:0]       quad_reg[0:CORDIC_STEPS];
    logic [IDX_W-1:0] cidx_reg[0:CORDIC_STEPS];
    logic             cinv_reg[0:CORDIC_STEPS];

    logic [PHASE_BITS-1:0] ph;
    logic [MW-1:0]         zprod;
    cordic_t               res, sr;
    logic signed [15:0]    s_next;

    logic                  sv_reg, mv_reg, ov_reg;
    logic signed [15:0]    s_reg;
    logic [IDX_W-1:0]      sidx_reg, midx_reg, oidx_reg;
    logic                  sinv_reg, minv_reg, oinv_reg;
    logic signed [TW-1:0]  prod_reg, base_reg, t;
    logic [CODE_W-1:0]     code_reg, code_next;

    // swing and valley in units of 2^-16 code, settled long before use
    assign a_min = (amplitude > FRAC_ONE) ? FRAC_ONE : amplitude;
    assign v_min = (valley > FRAC_ONE) ? FRAC_ONE : valley;

    always_ff @(posedge clk)
    begin
        ppraw_reg <= PW'(DAC_MAX_CODE) * PW'(a_min);
        lo_reg    <= PW'(DAC_MAX_CODE) * PW'(v_min);
        lo2_reg   <= lo_reg;
        pp_reg    <= ((lo_reg + ppraw_reg) > FULL) ? FULL - lo_reg : ppraw_reg;
    end

    // back pipeline moves while the output slot frees
    assign be  = !ov_reg || out_ch.ready;
    assign pop = be && !q_stat.empty;

    // stage zero: phase to angle
    assign ph    = pop_data[PHASE_BITS-1:0];
    assign zprod = MW'(ph[RW-1:0]) * MW'(HALF_PI_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else if (be)
        begin
            cv_reg[0] <= !q_stat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            x_reg[0]    <= CORDIC_X0;
            y_reg[0]    <= '0;
            z_reg[0]    <= CORDIC_W'(zprod >> RW);
            quad_reg[0] <= ph[PHASE_BITS-1:PHASE_BITS-2];
            cidx_reg[0] <= pop_data[QW-1:QW-IDX_W];
            cinv_reg[0] <= pop_data[PHASE_BITS];
        end
    end

    // cordic rotation stages
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        cordic_t dx, dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else if (be)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (be)
            begin
                if (!z_reg[i][CORDIC_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                quad_reg[i+1] <= quad_reg[i];
                cidx_reg[i+1] <= cidx_reg[i];
                cinv_reg[i+1] <= cinv_reg[i];
            end
        end
    end

    // quadrant fold and q1.15 rounding
    always_comb
    begin
        res = quad_reg[CORDIC_STEPS][0] ? x_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        if (quad_reg[CORDIC_STEPS][1])
        begin
            res = -res;
        end
        sr = (res + CORDIC_W'(16384)) >>> 15;
        if (sr > CORDIC_W'(32767))
        begin
            s_next = 16'sh7fff;
        end
        else if (sr < -CORDIC_W'(32768))
        begin
            s_next = -16'sh8000;
        end
        else
        begin
            s_next = sr[15:0];
        end
    end

    // final clamp and round half up
    always_comb
    begin
        t = base_reg + prod_reg;
        if (t < 0)
        begin
            t = '0;
        end
        else if (t > TOP)
        begin
            t = TOP;
        end
        t = t + HALF;
        code_next = minv_reg ? '0 : t[CODE_W+31:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= 1'b0;
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (be)
        begin
            sv_reg <= cv_reg[CORDIC_STEPS];
            mv_reg <= sv_reg;
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            s_reg    <= s_next;
            sidx_reg <= cidx_reg[CORDIC_STEPS];
            sinv_reg <= cinv_reg[CORDIC_STEPS];
            prod_reg <= TW'($signed({1'b0, pp_reg})) * TW'(s_reg);
            base_reg <= TW'({1'b0, (lo2_reg << 1) + pp_reg}) <<< 15;
            midx_reg <= sidx_reg;
            minv_reg <= sinv_reg;
            code_reg <= code_next;
            oidx_reg <= midx_reg;
            oinv_reg <= minv_reg;
        end
    end

    assign out_ch.valid         = ov_reg;
    assign out_ch.dac_code      = code_reg;
    assign out_ch.index_echo    = oidx_reg;
    assign out_ch.index_invalid = oinv_reg;

endmodule

// ===== design/dac_sine_table_point_unit.sv =====
// Sine table point unit: takes one point index a cycle while the front end is not
// stalled by a full queue, and returns the DAC code of that point of one sine period.
// Requests pass through the one-bit-a-stage phase division (PHASE_BITS + 2 stages) and
// the 16-stage cordic pipeline with its scaling stages. A four-entry queue separates
// the two, so the divider keeps taking requests while the output is held, until the
// queue fills. Register writes must land while no request is in flight.
module dac_sine_table_point_unit
    import dstp_pkg::*;
#(
    parameter int DAC_MAX_CODE = 4095,
    parameter int PHASE_BITS = 16,
    localparam int CODE_W = $clog2(DAC_MAX_CODE + 1),
    localparam int QW = IDX_W + 1 + PHASE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAC_W-1:0]    cfg_data,
    dstp_in_if.sink              in_ch,
    dstp_out_if.source           out_ch
);

    logic [FRAC_W-1:0] amp_reg, valley_reg;
    logic [IDX_W-1:0]  points_reg;
    logic              push, pop;
    logic [QW-1:0]     push_data, pop_data;
    q_status_t         q_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg    <= FRAC_ONE;
            valley_reg <= '0;
            points_reg <= 16'd128;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_AMPLITUDE: amp_reg    <= cfg_data;
                REG_VALLEY:    valley_reg <= cfg_data;
                REG_POINTS:    points_reg <= cfg_data[IDX_W-1:0];
                default:       ;
            endcase
        end
    end

    dstp_front #(.PHASE_BITS(PHASE_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .points    (points_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    dstp_queue #(.W(QW), .DEPTH(4)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    dstp_back #(
        .PHASE_BITS   (PHASE_BITS),
        .DAC_MAX_CODE (DAC_MAX_CODE),
        .CODE_W       (CODE_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .amplitude (amp_reg),
        .valley    (valley_reg),
        .pop_data  (pop_data),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

// ===== design/dstp_checker.sv =====
// port checker for the sine table point unit and its bind
`include "dac_sine_table_point_unit_defines.svh"

module dstp_checker
    import dstp_pkg::*;
#(
    parameter int DAC_MAX_CODE = 4095,
    parameter int CODE_W = 12
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CODE_W-1:0] dac_code,
    input logic [15:0]       index_echo,
    input logic              index_invalid
);

    // out-of-range index always gives code zero
    `DSTP_ASSERT_IMP(a_invalid_zero, out_valid && index_invalid, dac_code == '0)
    // code never exceeds full scale
    `DSTP_ASSERT_IMP(a_code_range, out_valid, dac_code <= CODE_W'(DAC_MAX_CODE))
    // a stalled result holds
    `DSTP_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(index_echo) && $stable(dac_code))

endmodule

bind dac_sine_table_point_unit dstp_checker #(
    .DAC_MAX_CODE (DAC_MAX_CODE),
    .CODE_W       (CODE_W)
) u_dstp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .dac_code      (out_ch.dac_code),
    .index_echo    (out_ch.index_echo),
    .index_invalid (out_ch.index_invalid)
);

// ===== tb/dstp_point_checker.sv =====
// checker for the sine table point unit: predicts each dac code and compares results
module dstp_point_checker
    import dstp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAC_W-1:0]    cfg_data,
    dstp_in_if                   in_ch,
    dstp_out_if                  out_ch,
    output int                   errors,
    output int                   pending
);

    localparam longint DAC_MAX = 4095;
    localparam int     PH_BITS = 16;

    typedef struct packed {
        logic [11:0] dac_code;
        logic [15:0] index_echo;
        logic        index_invalid;
    } point_result_t;

    // arctangent steps in q2.30
    localparam longint ATAN_STEP [16] = '{
        843314857, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437,
        4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767
    };

    logic [16:0]   amp_reg;
    logic [16:0]   valley_reg;
    logic [15:0]   points_reg;
    point_result_t code_queue [$];

    // q1.15 sine of a turn phase through a 16-step rotation
    function automatic longint sine_of_phase(input logic [15:0] phase);
        longint x, y, z, dx, dy, res, s;
        x = 652032874;
        y = 0;
        z = (longint'(phase[13:0]) * 1686629713) >>> (PH_BITS - 2);
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        res = phase[14] ? x : y;
        if (phase[15])
            res = -res;
        s = (res + 16384) >>> 15;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return s;
    endfunction

    function automatic point_result_t dac_point(input logic [15:0] idx);
        point_result_t r;
        longint n, a, v, pp, lo, full, ph, s, t, top;
        r.index_echo = idx;
        n = points_reg;
        if (n == 0 || longint'(idx) >= n)
        begin
            r.dac_code = '0;
            r.index_invalid = 1'b1;
            return r;
        end
        a = (amp_reg > 17'h10000) ? 65536 : amp_reg;
        v = (valley_reg > 17'h10000) ? 65536 : valley_reg;
        full = DAC_MAX * 65536;
        pp = DAC_MAX * a;
        lo = DAC_MAX * v;
        if (lo + pp > full)
            pp = full - lo;
        ph = ((longint'(idx) <<< (PH_BITS + 1)) + n) / (2 * n);
        s = sine_of_phase(ph[15:0]);
        t = ((2 * lo + pp) <<< 15) + pp * s;
        top = DAC_MAX <<< 32;
        if (t < 0)
            t = 0;
        if (t > top)
            t = top;
        t = (t + (longint'(1) <<< 31)) >>> 32;
        r.dac_code = t[11:0];
        r.index_invalid = 1'b0;
        return r;
    endfunction

    assign pending = code_queue.size();

    // register shadow, request prediction and result comparison
    always @(posedge clk or negedge rst_n)
    begin
        point_result_t exp_r;
        if (!rst_n)
        begin
            amp_reg    <= 17'h10000;
            valley_reg <= '0;
            points_reg <= 16'd128;
            errors     <= 0;
            code_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_AMPLITUDE: amp_reg <= cfg_data;
                    REG_VALLEY:    valley_reg <= cfg_data;
                    REG_POINTS:    points_reg <= cfg_data[15:0];
                    default:       ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                code_queue.push_back(dac_point(in_ch.point_index));
            if (out_ch.valid && out_ch.ready)
            begin
                if (code_queue.size() == 0)
                begin
                    $display("%0t: unexpected result code %0d echo %0d invalid %0b",
                             $time, out_ch.dac_code, out_ch.index_echo,
                             out_ch.index_invalid);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = code_queue.pop_front();
                    if (exp_r.dac_code !== out_ch.dac_code ||
                        exp_r.index_echo !== out_ch.index_echo ||
                        exp_r.index_invalid !== out_ch.index_invalid)
                    begin
                        $display("%0t: mismatch exp code %0d echo %0d inv %0b, got %0d %0d %0b",
                                 $time, exp_r.dac_code, exp_r.index_echo,
                                 exp_r.index_invalid, out_ch.dac_code,
                                 out_ch.index_echo, out_ch.index_invalid);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// top of the sine table point unit testbench: clock, stimulus and verdict
module tb_top;
    import dstp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FRAC_W-1:0]    cfg_data;
    int                   errors;
    int                   pending;
    int                   cycles;
    bit                   no_idle;
    bit                   hold_req;

    dstp_in_if                 in_if ();
    dstp_out_if #(.CODE_W(12)) out_if ();

    dac_sine_table_point_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    dstp_point_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL dac_sine_table_point_unit");
            $finish;
        end
    end

    // result side: random stalls and one long hold-off
    initial
    begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_if.ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_done = 1'b1;
            end
            gap = no_idle ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                out_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (!out_if.valid)
                @(posedge clk);
        end
    end

    task automatic send_point(input logic [15:0] idx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.point_index <= idx;
        in_if.valid <= 1'b1;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // writes happen only once every request has drained
    task automatic write_regs(input logic [16:0] amp, input logic [16:0] valley,
                              input logic [15:0] points);
        in_if.valid <= 1'b0;
        wait (pending == 0);
        repeat (45) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_AMPLITUDE;
        cfg_data <= amp;
        @(negedge clk);
        cfg_index <= REG_VALLEY;
        cfg_data <= valley;
        @(negedge clk);
        cfg_index <= REG_POINTS;
        cfg_data <= {1'b0, points};
        @(negedge clk);
        cfg_we <= 1'b0;
        repeat (4) @(negedge clk);
    endtask

    task automatic random_phase(input int count, input logic [15:0] points);
        logic [15:0] idx;
        for (int i = 0; i < count; i++)
        begin
            if (points != 0 && $urandom_range(0, 99) < 85)
                idx = $urandom_range(0, points - 1);
            else
                idx = $urandom;
            send_point(idx);
        end
    endtask

    initial
    begin
        logic [16:0] amp;
        logic [16:0] valley;
        logic [15:0] points;
        int sel;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_AMPLITUDE;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.point_index = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: quarter points, last point, out of range
        send_point(16'd0);
        send_point(16'd32);
        send_point(16'd64);
        send_point(16'd96);
        send_point(16'd127);
        send_point(16'd128);
        send_point(16'hFFFF);
        // fractions above one, valley at full scale
        write_regs(17'h1FFFF, 17'h1FFFF, 16'd4);
        send_point(16'd0);
        send_point(16'd1);
        send_point(16'd3);
        send_point(16'd4);
        // zero swing, zero point count
        write_regs(17'd0, 17'h08000, 16'd0);
        send_point(16'd0);
        send_point(16'd5);
        // single point, then the largest count
        write_regs(17'h10000, 17'd0, 16'd1);
        send_point(16'd0);
        send_point(16'd1);
        write_regs(17'h0C000, 17'h06000, 16'hFFFF);
        send_point(16'd0);
        send_point(16'd16384);
        send_point(16'd32768);
        send_point(16'd49152);
        send_point(16'hFFFE);
        send_point(16'hFFFF);

        // random settings, mostly small tables
        for (int ph = 0; ph < 12; ph++)
        begin
            sel = $urandom_range(0, 9);
            amp = (sel < 2) ? 17'($urandom) : 17'($urandom_range(0, 65536));
            valley = (sel == 3) ? 17'($urandom) : 17'($urandom_range(0, 40000));
            if (sel == 4)
                points = 16'($urandom);
            else if (sel == 5)
                points = 16'hFFFF;
            else
                points = 16'($urandom_range(1, 300));
            write_regs(amp, valley, points);
            // back-to-back requests while the result side holds off fill the block
            no_idle = (ph % 4 == 1) || (ph == 6);
            hold_req = (ph == 6);
            random_phase(110, points);
            no_idle = 1'b0;
        end

        in_if.valid <= 1'b0;
        wait (pending == 0);
        repeat (45) @(negedge clk);
        if (errors == 0)
            $display("PASS dac_sine_table_point_unit");
        else
            $display("FAIL dac_sine_table_point_unit");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/dstp_pkg.sv
design/dstp_ifs.sv
design/dstp_front.sv
design/dstp_queue.sv
design/dstp_back.sv
design/dac_sine_table_point_unit.sv
design/dstp_checker.sv
tb/dstp_point_checker.sv
tb/tb_top.sv
